// ===== hw/rtl/bth_pkg.sv =====
// Shared types, constants and helper functions of the boundary tag heap allocator.
`default_nettype none
package bth_pkg;

   localparam int HEAP_AW    = 16;
   localparam int HEAP_WORDS = 1 << HEAP_AW;
   localparam int HEAP_BYTES = HEAP_WORDS * 4;
   localparam int ADR_W      = 36;
   localparam int SZ_W       = 34;
   localparam int CHUNK_W    = 19;
   localparam int ASZ_W      = 20;
   localparam int HEND_W     = HEAP_AW + 3;
   localparam int BADDR_W    = 18;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_ZERO = 2'd1,
      ST_FULL = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_CLR, S_RI0, S_RI1, S_RI2, S_RI3,
      S_IDLE, S_RESP,
      S_AF_RD, S_AF_CHK, S_GROW_CK, S_GR0, S_GR1, S_GR2,
      S_PL0, S_PL1, S_PL2, S_PL3,
      S_FR0, S_FR1, S_FR2,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_MP1, S_MP2, S_MN1, S_MN2,
      S_MB2, S_MB3, S_MB4, S_MB5
   } state_type;

   // Size field of a tag word.
   function automatic logic [31:0] tag_size(input logic [31:0] w);
      tag_size = {w[31:3], 3'b000};
   endfunction

   // A byte offset lies in the store when its upper bits are all zero.
   function automatic logic in_heap(input logic [ADR_W-1:0] a);
      in_heap = (a[ADR_W-1:HEAP_AW+2] == '0);
   endfunction

   // Growth quantum: chunk rounded up to 8, at least 8.
   function automatic logic [ASZ_W-1:0] chunk_round(input logic [CHUNK_W-1:0] c);
      logic [ASZ_W-1:0] r;
      r = (ASZ_W'(c) + ASZ_W'(7)) & ~ASZ_W'(7);
      chunk_round = (r == '0) ? ASZ_W'(8) : r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bth_ram.sv =====
// Single write port, single registered read port word memory for the heap store.
`default_nettype none
module bth_ram #(
   parameter int AW = 16,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:(1<<AW)-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/boundary_tag_heap_allocator.sv =====
// Top level of the boundary tag heap allocator: command sequencer, break register and CSR.
// One transaction at a time; an allocation walks the block headers over the single read port
// of the heap memory. The result strobe lasts one cycle; the receiver cannot stall.
// Reset: a clearing pass writes zero to all 65536 heap words, then the starting layout is
// built; busy stays high throughout.
`default_nettype none
module boundary_tag_heap_allocator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [18:0]                req_size,
   input  wire logic [17:0]                req_block_addr,
   output logic                            rsp_valid,
   output logic [17:0]                     rsp_result_addr,
   output logic [1:0]                      rsp_status,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [1:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int AW = bth_pkg::ADR_W;

   // Sequencer state and the transaction being worked on.
   bth_pkg::state_type state_ff, state_in;
   bth_pkg::cmd_type   cmd_ff, cmd_in;
   logic               boot_ff, boot_in;
   logic [bth_pkg::HEAP_AW-1:0] clr_ff, clr_in;
   logic [bth_pkg::HEND_W-1:0]  hend_ff, hend_in;
   logic [bth_pkg::CHUNK_W-1:0] chunk_ff;

   // Working registers of the shared address datapath.
   logic [AW-1:0]              bp_ff, bp_in;
   logic [AW-1:0]              aux_ff, aux_in;
   logic [AW-1:0]              nx_ff, nx_in;
   logic [31:0]                hsz_ff, hsz_in;
   logic [31:0]                sp_ff, sp_in;
   logic [bth_pkg::SZ_W-1:0]   sz_ff, sz_in;
   logic [bth_pkg::ASZ_W-1:0]  asize_ff, asize_in;
   logic                       pa_ff, pa_in;
   logic [17:0]                res_ff, res_in;
   bth_pkg::status_type        stat_ff, stat_in;
   logic                       rvalid_ff;

   // Memory access requests, addressed by byte offset.
   logic [AW-1:0] rd_a;
   logic [AW-1:0] wr_a;
   logic          wr_en;
   logic [31:0]   wr_d;
   logic [31:0]   ram_q;
   logic [31:0]   rd_word;
   logic [31:0]   rtag;
   logic [AW-1:0] rtag_x;

   logic [bth_pkg::ASZ_W-1:0] crnd;
   logic [bth_pkg::ASZ_W-1:0] ext;
   logic [AW-1:0]             hend_x;
   logic                      split;
   logic [bth_pkg::SZ_W-1:0]  sum3;

   bth_ram #(.AW(bth_pkg::HEAP_AW), .DW(32)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en & bth_pkg::in_heap(wr_a)),
      .wr_addr (wr_a[bth_pkg::HEAP_AW+1:2]),
      .wr_data (wr_d),
      .rd_addr (rd_a[bth_pkg::HEAP_AW+1:2]),
      .rd_data (ram_q)
   );

   // A read outside the store returns zero.
   assign rd_word = rvalid_ff ? ram_q : 32'd0;
   assign rtag    = bth_pkg::tag_size(rd_word);
   assign rtag_x  = AW'(rtag);

   assign crnd   = bth_pkg::chunk_round(boot_ff ? bth_pkg::CHUNK_RESET : chunk_ff);
   assign ext    = (cmd_ff == bth_pkg::CMD_ALLOC && asize_ff > crnd) ? asize_ff : crnd;
   assign hend_x = AW'(hend_ff);
   assign split  = sz_ff >= (bth_pkg::SZ_W'(asize_ff) + bth_pkg::SZ_W'(16));
   assign sum3   = bth_pkg::SZ_W'(hsz_ff) + bth_pkg::SZ_W'(sp_ff) + bth_pkg::SZ_W'(rtag);

   assign busy            = (state_ff != bth_pkg::S_IDLE);
   assign rsp_valid       = (state_ff == bth_pkg::S_RESP);
   assign rsp_result_addr = res_ff;
   assign rsp_status      = stat_ff;
   assign pready          = 1'b1;
   // The chunk register is the only register; it reads at address 0, and a write at any address sets it.
   assign prdata          = (paddr == 2'd0) ? 32'(chunk_ff) : 32'd0;

   // Next state and memory requests. Every read is issued one state ahead of its use.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      boot_in  = boot_ff;
      clr_in   = clr_ff;
      hend_in  = hend_ff;
      bp_in    = bp_ff;
      aux_in   = aux_ff;
      nx_in    = nx_ff;
      hsz_in   = hsz_ff;
      sp_in    = sp_ff;
      sz_in    = sz_ff;
      asize_in = asize_ff;
      pa_in    = pa_ff;
      res_in   = res_ff;
      stat_in  = stat_ff;
      rd_a     = '0;
      wr_en    = 1'b0;
      wr_a     = '0;
      wr_d     = '0;
      unique case (state_ff)
         bth_pkg::S_CLR: begin
            wr_en  = 1'b1;
            wr_a   = AW'({clr_ff, 2'b00});
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = bth_pkg::S_RI0;
            end
         end
         bth_pkg::S_RI0: begin
            wr_en    = 1'b1;
            wr_a     = AW'(0);
            state_in = bth_pkg::S_RI1;
         end
         bth_pkg::S_RI1: begin
            wr_en    = 1'b1;
            wr_a     = AW'(4);
            wr_d     = 32'd9;
            state_in = bth_pkg::S_RI2;
         end
         bth_pkg::S_RI2: begin
            wr_en    = 1'b1;
            wr_a     = AW'(8);
            wr_d     = 32'd9;
            state_in = bth_pkg::S_RI3;
         end
         bth_pkg::S_RI3: begin
            wr_en    = 1'b1;
            wr_a     = AW'(12);
            wr_d     = 32'd1;
            hend_in  = bth_pkg::HEND_W'(16);
            state_in = bth_pkg::S_GROW_CK;
         end
         bth_pkg::S_IDLE: begin
            if (start) begin
               cmd_in  = bth_pkg::cmd_type'(req_cmd);
               res_in  = '0;
               stat_in = bth_pkg::ST_DONE;
               bp_in   = AW'(req_block_addr);
               unique case (bth_pkg::cmd_type'(req_cmd))
                  bth_pkg::CMD_ALLOC: begin
                     if (req_size == '0) begin
                        stat_in  = bth_pkg::ST_ZERO;
                        state_in = bth_pkg::S_RESP;
                     end else begin
                        if (req_size <= 19'd8) begin
                           asize_in = bth_pkg::ASZ_W'(16);
                        end else begin
                           asize_in = (bth_pkg::ASZ_W'(req_size) + bth_pkg::ASZ_W'(15))
                                      & ~bth_pkg::ASZ_W'(7);
                        end
                        bp_in    = AW'(8);
                        state_in = bth_pkg::S_AF_RD;
                     end
                  end
                  bth_pkg::CMD_FREE:   state_in = bth_pkg::S_FR0;
                  bth_pkg::CMD_REINIT: state_in = bth_pkg::S_RI0;
                  bth_pkg::CMD_NOP:    state_in = bth_pkg::S_RESP;
                  default:             state_in = bth_pkg::S_RESP;
               endcase
            end
         end
         bth_pkg::S_RESP: begin
            state_in = bth_pkg::S_IDLE;
         end
         bth_pkg::S_AF_RD: begin
            rd_a     = bp_ff - AW'(4);
            state_in = bth_pkg::S_AF_CHK;
         end
         bth_pkg::S_AF_CHK: begin
            if (rtag == 32'd0) begin
               state_in = bth_pkg::S_GROW_CK;
            end else if (!rd_word[0] && (32'(asize_ff) <= rtag)) begin
               sz_in    = bth_pkg::SZ_W'(rtag);
               state_in = bth_pkg::S_PL0;
            end else begin
               bp_in = bp_ff + rtag_x;
               if ((bp_ff + rtag_x) > hend_x) begin
                  state_in = bth_pkg::S_GROW_CK;
               end else begin
                  state_in = bth_pkg::S_AF_RD;
               end
            end
         end
         bth_pkg::S_GROW_CK: begin
            if ((hend_x + AW'(ext)) > AW'(bth_pkg::HEAP_BYTES)) begin
               stat_in = bth_pkg::ST_FULL;
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = bth_pkg::S_IDLE;
               end else begin
                  state_in = bth_pkg::S_RESP;
               end
            end else begin
               sz_in    = bth_pkg::SZ_W'(ext);
               bp_in    = hend_x;
               state_in = bth_pkg::S_GR0;
            end
         end
         bth_pkg::S_GR0: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff - AW'(4);
            wr_d     = sz_ff[31:0];
            state_in = bth_pkg::S_GR1;
         end
         bth_pkg::S_GR1: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff + AW'(sz_ff) - AW'(8);
            wr_d     = sz_ff[31:0];
            state_in = bth_pkg::S_GR2;
         end
         bth_pkg::S_GR2: begin
            wr_en   = 1'b1;
            wr_a    = bp_ff + AW'(sz_ff) - AW'(4);
            wr_d    = 32'd1;
            hend_in = bth_pkg::HEND_W'(bp_ff + AW'(sz_ff));
            if (cmd_ff == bth_pkg::CMD_ALLOC) begin
               state_in = bth_pkg::S_PL0;
            end else if (boot_ff) begin
               boot_in  = 1'b0;
               state_in = bth_pkg::S_IDLE;
            end else begin
               state_in = bth_pkg::S_RESP;
            end
         end
         bth_pkg::S_PL0: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff - AW'(4);
            wr_d     = split ? (32'(asize_ff) | 32'd1) : (sz_ff[31:0] | 32'd1);
            state_in = bth_pkg::S_PL1;
         end
         bth_pkg::S_PL1: begin
            wr_en = 1'b1;
            if (split) begin
               wr_a     = bp_ff + AW'(asize_ff) - AW'(8);
               wr_d     = 32'(asize_ff) | 32'd1;
               state_in = bth_pkg::S_PL2;
            end else begin
               wr_a     = bp_ff + AW'(sz_ff) - AW'(8);
               wr_d     = sz_ff[31:0] | 32'd1;
               res_in   = bp_ff[17:0];
               state_in = bth_pkg::S_RESP;
            end
         end
         bth_pkg::S_PL2: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff + AW'(asize_ff) - AW'(4);
            wr_d     = sz_ff[31:0] - 32'(asize_ff);
            state_in = bth_pkg::S_PL3;
         end
         bth_pkg::S_PL3: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff + AW'(sz_ff) - AW'(8);
            wr_d     = sz_ff[31:0] - 32'(asize_ff);
            res_in   = bp_ff[17:0];
            state_in = bth_pkg::S_RESP;
         end
         bth_pkg::S_FR0: begin
            rd_a     = bp_ff - AW'(4);
            state_in = bth_pkg::S_FR1;
         end
         bth_pkg::S_FR1: begin
            hsz_in   = rtag;
            wr_en    = 1'b1;
            wr_a     = bp_ff - AW'(4);
            wr_d     = rtag;
            state_in = bth_pkg::S_FR2;
         end
         bth_pkg::S_FR2: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff + AW'(hsz_ff) - AW'(8);
            wr_d     = hsz_ff;
            state_in = bth_pkg::S_M0;
         end
         bth_pkg::S_M0: begin
            rd_a     = bp_ff - AW'(8);
            state_in = bth_pkg::S_M1;
         end
         bth_pkg::S_M1: begin
            aux_in   = bp_ff - rtag_x;
            rd_a     = bp_ff - rtag_x - AW'(4);
            state_in = bth_pkg::S_M2;
         end
         bth_pkg::S_M2: begin
            sp_in    = rtag;
            rd_a     = aux_ff + rtag_x - AW'(8);
            state_in = bth_pkg::S_M3;
         end
         bth_pkg::S_M3: begin
            pa_in    = rd_word[0];
            rd_a     = bp_ff - AW'(4);
            state_in = bth_pkg::S_M4;
         end
         bth_pkg::S_M4: begin
            hsz_in   = rtag;
            nx_in    = bp_ff + rtag_x;
            rd_a     = bp_ff + rtag_x - AW'(4);
            state_in = bth_pkg::S_M5;
         end
         bth_pkg::S_M5: begin
            priority if (pa_ff && rd_word[0]) begin
               state_in = bth_pkg::S_RESP;
            end else if (pa_ff) begin
               sz_in    = bth_pkg::SZ_W'(hsz_ff) + bth_pkg::SZ_W'(rtag);
               wr_en    = 1'b1;
               wr_a     = bp_ff - AW'(4);
               wr_d     = hsz_ff + rtag;
               state_in = bth_pkg::S_MP1;
            end else if (rd_word[0]) begin
               sz_in    = bth_pkg::SZ_W'(hsz_ff) + bth_pkg::SZ_W'(sp_ff);
               wr_en    = 1'b1;
               wr_a     = bp_ff + AW'(hsz_ff) - AW'(8);
               wr_d     = hsz_ff + sp_ff;
               state_in = bth_pkg::S_MN1;
            end else begin
               rd_a     = nx_ff + rtag_x - AW'(8);
               state_in = bth_pkg::S_MB2;
            end
         end
         bth_pkg::S_MP1: begin
            rd_a     = bp_ff - AW'(4);
            state_in = bth_pkg::S_MP2;
         end
         bth_pkg::S_MP2: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff + rtag_x - AW'(8);
            wr_d     = sz_ff[31:0];
            state_in = bth_pkg::S_RESP;
         end
         bth_pkg::S_MN1: begin
            rd_a     = bp_ff - AW'(8);
            state_in = bth_pkg::S_MN2;
         end
         bth_pkg::S_MN2: begin
            wr_en    = 1'b1;
            wr_a     = bp_ff - rtag_x - AW'(4);
            wr_d     = sz_ff[31:0];
            state_in = bth_pkg::S_RESP;
         end
         bth_pkg::S_MB2: begin
            sz_in    = sum3;
            wr_en    = 1'b1;
            wr_a     = aux_ff - AW'(4);
            wr_d     = sum3[31:0];
            state_in = bth_pkg::S_MB3;
         end
         bth_pkg::S_MB3: begin
            rd_a     = bp_ff - AW'(4);
            state_in = bth_pkg::S_MB4;
         end
         bth_pkg::S_MB4: begin
            nx_in    = bp_ff + rtag_x;
            rd_a     = bp_ff + rtag_x - AW'(4);
            state_in = bth_pkg::S_MB5;
         end
         bth_pkg::S_MB5: begin
            wr_en    = 1'b1;
            wr_a     = nx_ff + rtag_x - AW'(8);
            wr_d     = sz_ff[31:0];
            state_in = bth_pkg::S_RESP;
         end
         default: begin
            state_in = bth_pkg::S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bth_pkg::S_CLR;
         cmd_ff   <= bth_pkg::CMD_REINIT;
         boot_ff  <= 1'b1;
         clr_ff   <= '0;
         hend_ff  <= '0;
         chunk_ff <= bth_pkg::CHUNK_RESET;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         boot_ff  <= boot_in;
         clr_ff   <= clr_in;
         hend_ff  <= hend_in;
         if (psel && penable && pwrite && pready) begin
            chunk_ff <= pwdata[bth_pkg::CHUNK_W-1:0];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bp_ff     <= bp_in;
      aux_ff    <= aux_in;
      nx_ff     <= nx_in;
      hsz_ff    <= hsz_in;
      sp_ff     <= sp_in;
      sz_ff     <= sz_in;
      asize_ff  <= asize_in;
      pa_ff     <= pa_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
      rvalid_ff <= bth_pkg::in_heap(rd_a);
   end

   // An accepted transaction keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   // A result strobe lasts exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Only a completed allocation reports an address.
   a_addr_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bth_pkg::ST_DONE) |-> (rsp_result_addr == '0))
      else $error("nonzero address with an error status");

   // The break never passes the end of the store.
   a_break_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bth_pkg::S_IDLE) |-> (32'(hend_ff) <= 32'(bth_pkg::HEAP_BYTES)))
      else $error("heap break beyond the store");

endmodule
`default_nettype wire

// ===== verif/boundary_tag_heap_allocator_test.sv =====
// Testbench for the boundary tag heap allocator: directed and random command streams checked against a predictor.
`default_nettype none
module boundary_tag_heap_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef bit [63:0] u64_type;

   // One expected response: the payload offset and the status code.
   typedef struct {
      bit [17:0]           addr;
      bth_pkg::status_type st;
   } reply_type;

   // The scoreboard keeps its own image of the heap words, the break and the
   // growth quantum. All offsets are 64-bit unsigned, so that an offset below
   // zero wraps to a huge value and simply falls outside the store.
   class alloc_scoreboard;
      bit [31:0] words[bth_pkg::HEAP_WORDS];
      u64_type   brk;
      u64_type   chunk;
      int        errors;
      reply_type pending[$];

      function new();
         foreach (words[i]) words[i] = '0;
         chunk  = 4096;
         errors = 0;
         void'(build_layout(grow_quantum()));
      endfunction

      function bit [31:0] rd(u64_type a);
         return ((a >> 2) < bth_pkg::HEAP_WORDS) ? words[a >> 2] : 32'd0;
      endfunction

      function void wr(u64_type a, u64_type v);
         if ((a >> 2) < bth_pkg::HEAP_WORDS) words[a >> 2] = v[31:0];
      endfunction

      function u64_type tsz(u64_type a);
         return u64_type'(rd(a) & 32'hFFFF_FFF8);
      endfunction

      function bit talloc(u64_type a);
         bit [31:0] w;
         w = rd(a);
         return w[0];
      endfunction

      function u64_type ftr(u64_type bp);
         return bp + tsz(bp - 4) - 8;
      endfunction

      function u64_type nxt(u64_type bp);
         return bp + tsz(bp - 4);
      endfunction

      function u64_type prv(u64_type bp);
         return bp - tsz(bp - 8);
      endfunction

      function u64_type grow_quantum();
         u64_type c;
         c = (chunk + 7) & ~u64_type'(7);
         return (c < 8) ? 8 : c;
      endfunction

      // The new block starts at the old break; the epilogue moves up behind it.
      function bit grow(u64_type bytes);
         u64_type bp;
         bp = brk;
         if (bp + bytes > bth_pkg::HEAP_WORDS * 4) return 0;
         wr(bp - 4, bytes);
         wr(ftr(bp), bytes);
         wr(nxt(bp) - 4, 1);
         brk = bp + bytes;
         return 1;
      endfunction

      function bit build_layout(u64_type c);
         wr(0, 0);
         wr(4, 9);
         wr(8, 9);
         wr(12, 1);
         brk = 16;
         return grow(c);
      endfunction

      // First fit from the prologue; a zero-size header or passing the break ends the walk.
      function u64_type first_fit(u64_type asize);
         u64_type bp, sz;
         bp = 8;
         forever begin
            sz = tsz(bp - 4);
            if (sz == 0) return 0;
            if (!talloc(bp - 4) && asize <= sz) return bp;
            bp += sz;
            if (bp > brk) return 0;
         end
      endfunction

      function void place(u64_type bp, u64_type asize);
         u64_type csize;
         csize = tsz(bp - 4);
         if (csize >= asize + 16) begin
            wr(bp - 4, asize | 1);
            wr(ftr(bp), asize | 1);
            bp = nxt(bp);
            wr(bp - 4, csize - asize);
            wr(ftr(bp), csize - asize);
         end else begin
            wr(bp - 4, csize | 1);
            wr(ftr(bp), csize | 1);
         end
      endfunction

      function void coalesce(u64_type bp);
         bit pa, na;
         u64_type size;
         pa   = talloc(ftr(prv(bp)));
         na   = talloc(nxt(bp) - 4);
         size = tsz(bp - 4);
         if (pa && na) return;
         if (pa) begin
            size += tsz(nxt(bp) - 4);
            wr(bp - 4, size);
            wr(ftr(bp), size);
         end else if (na) begin
            size += tsz(prv(bp) - 4);
            wr(ftr(bp), size);
            wr(prv(bp) - 4, size);
         end else begin
            size += tsz(prv(bp) - 4) + tsz(ftr(nxt(bp)));
            wr(prv(bp) - 4, size);
            wr(ftr(nxt(bp)), size);
         end
      endfunction

      // Applies one accepted transaction to the heap image and queues its response.
      function reply_type note_command(bth_pkg::cmd_type c, bit [18:0] req, bit [17:0] baddr);
         reply_type r;
         u64_type asize, bp, ext, size, a;
         r.addr = '0;
         r.st   = bth_pkg::ST_DONE;
         a      = u64_type'(baddr);
         unique case (c)
            bth_pkg::CMD_ALLOC: begin
               if (req == 0) begin
                  r.st = bth_pkg::ST_ZERO;
               end else begin
                  asize = (req <= 8) ? 16 : 8 * ((u64_type'(req) + 15) / 8);
                  bp = first_fit(asize);
                  if (bp != 0) begin
                     place(bp, asize);
                     r.addr = bp[17:0];
                  end else begin
                     ext = grow_quantum();
                     if (asize > ext) ext = asize;
                     bp = brk;
                     if (grow(ext)) begin
                        place(bp, asize);
                        r.addr = bp[17:0];
                     end else begin
                        r.st = bth_pkg::ST_FULL;
                     end
                  end
               end
            end
            bth_pkg::CMD_FREE: begin
               size = tsz(a - 4);
               wr(a - 4, size);
               wr(ftr(a), size);
               coalesce(a);
            end
            bth_pkg::CMD_REINIT: begin
               if (!build_layout(grow_quantum())) r.st = bth_pkg::ST_FULL;
            end
            default: ;
         endcase
         pending.push_back(r);
         return r;
      endfunction

      function void check_response(bit [17:0] addr, bit [1:0] st);
         reply_type e;
         if (pending.size() == 0) begin
            $error("response with nothing expected: result_addr %0h status %0d", addr, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (addr !== e.addr) begin
            $error("result_addr: expected %0h, got %0h", e.addr, addr);
            errors++;
         end
         if (st !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, st);
            errors++;
         end
      endfunction
   endclass

   localparam longint CYCLE_LIMIT = 6_000_000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [18:0] req_size;
   logic [17:0] req_block_addr;
   logic        rsp_valid;
   logic [17:0] rsp_result_addr;
   logic [1:0]  rsp_status;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   boundary_tag_heap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_size(req_size), .req_block_addr(req_block_addr),
      .rsp_valid(rsp_valid), .rsp_result_addr(rsp_result_addr), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   alloc_scoreboard sb = new();
   longint cycles = 0;
   int     sent = 0;          // transactions accepted so far, used for the idle pattern
   bit [17:0] live[$];        // payload offsets that are currently allocated

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. The limit covers the clearing pass after reset plus generous
   // room for long first-fit walks when the heap holds many blocks.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("boundary_tag_heap_allocator_test failed");
         $finish;
      end
   end

   // Results cannot be held off, so every strobe is checked at the edge that ends it.
   // Reading right after the edge sees the values from before it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_result_addr, rsp_status);
   end

   // About 35 of 100 transactions are preceded by a random gap, except for a
   // long stretch in the middle of the run where the sender never idles.
   function automatic int pick_gap();
      if (sent >= 700 && sent < 1000) return 0;
      return ($urandom_range(99) < 35) ? $urandom_range(1, 6) : 0;
   endfunction

   // Presents one transaction and waits for the edge that accepts it. start stays
   // high afterwards, so a following transaction is taken as soon as the block is idle.
   task automatic send(input bth_pkg::cmd_type c, input bit [18:0] sz, input bit [17:0] ba,
                       output reply_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd        <= c;
      req_size       <= sz;
      req_block_addr <= ba;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      r = sb.note_command(c, sz, ba);
      sent++;
      if (c == bth_pkg::CMD_ALLOC && r.st == bth_pkg::ST_DONE) live.push_back(r.addr);
      if (c == bth_pkg::CMD_REINIT) live.delete();
   endtask

   // Lets every expected response arrive, then a further margin for the
   // block's own trailing cycles, so that the block is idle.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_chunk(input bit [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 2'd0;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.chunk = u64_type'(value[18:0]);
   endtask

   function automatic bit [18:0] random_size();
      int r;
      r = $urandom_range(99);
      if (r < 1) return 19'd0;
      if (r < 70) return 19'($urandom_range(1, 256));
      if (r < 90) return 19'($urandom_range(257, 4096));
      if (r < 98) return 19'($urandom_range(4097, 40000));
      return 19'($urandom);
   endfunction

   // Random phase: mostly well-formed allocate and free of live blocks, with
   // some unused commands, reinitializations and frees of arbitrary offsets.
   // A free of an arbitrary offset may corrupt the tags, so a reinitialize
   // follows it and the list of live blocks is forgotten.
   task automatic random_phase(input int count);
      reply_type r;
      int        sel, k;
      bit        rebuild;
      rebuild = 0;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (rebuild) begin
            send(bth_pkg::CMD_REINIT, 19'($urandom), 18'($urandom), r);
            rebuild = 0;
         end else if ((sel < 45 || live.size() == 0) && live.size() < 80) begin
            send(bth_pkg::CMD_ALLOC, random_size(), 18'($urandom), r);
         end else if (sel < 90) begin
            k = $urandom_range(live.size() - 1);
            send(bth_pkg::CMD_FREE, 19'($urandom), live[k], r);
            live.delete(k);
         end else if (sel < 94) begin
            send(bth_pkg::CMD_NOP, 19'($urandom), 18'($urandom), r);
         end else if (sel < 97) begin
            send(bth_pkg::CMD_REINIT, 19'($urandom), 18'($urandom), r);
         end else begin
            send(bth_pkg::CMD_FREE, 19'($urandom), 18'($urandom), r);
            rebuild = 1;
         end
      end
   endtask

   initial begin
      reply_type r, a1, a2, a3;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_cmd        <= bth_pkg::CMD_NOP;
      req_size       <= '0;
      req_block_addr <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The clearing pass keeps busy high; wait it out before touching the register.
      @(posedge clock);
      while (busy) @(posedge clock);
      write_chunk(32'd4096);

      // Directed part: sizing corners, splitting, merging in both directions,
      // growth, a full heap, the unused command and frees of arbitrary offsets.
      send(bth_pkg::CMD_ALLOC, 19'd0, 18'h3FFFF, r);
      send(bth_pkg::CMD_ALLOC, 19'd1, 18'd0, a1);
      send(bth_pkg::CMD_ALLOC, 19'd8, 18'd0, a2);
      send(bth_pkg::CMD_ALLOC, 19'd9, 18'd0, a3);
      send(bth_pkg::CMD_ALLOC, 19'd24, 18'd0, r);
      send(bth_pkg::CMD_FREE, 19'h7FFFF, a2.addr, r);
      send(bth_pkg::CMD_FREE, 19'd0, a1.addr, r);
      send(bth_pkg::CMD_FREE, 19'd0, a3.addr, r);
      send(bth_pkg::CMD_ALLOC, 19'd4000, 18'd0, r);
      send(bth_pkg::CMD_ALLOC, 19'd5000, 18'd0, r);
      send(bth_pkg::CMD_ALLOC, 19'd262144, 18'd0, r);
      send(bth_pkg::CMD_ALLOC, 19'd4072, 18'd0, r);
      send(bth_pkg::CMD_NOP, 19'h7FFFF, 18'h3FFFF, r);
      send(bth_pkg::CMD_FREE, 19'd0, 18'd0, r);
      send(bth_pkg::CMD_FREE, 19'd0, 18'h3FFFF, r);
      send(bth_pkg::CMD_FREE, 19'd0, 18'd2, r);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      send(bth_pkg::CMD_ALLOC, 19'd16, 18'd0, r);
      drain();

      // Phases with different growth quanta, each started from a rebuilt heap.
      // The sender waits for every response before each register write.
      write_chunk(32'd0);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(300);
      drain();
      write_chunk(32'd8);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(300);
      drain();
      // A quantum as large as the store: the rebuild itself does not fit and the heap stays empty.
      write_chunk(32'd262144);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(40);
      drain();
      write_chunk(32'hFFFF_FFFF);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(20);
      drain();
      write_chunk($urandom_range(9, 20000));
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(500);
      drain();
      write_chunk(32'd4096);
      send(bth_pkg::CMD_REINIT, 19'd0, 18'd0, r);
      random_phase(690);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("boundary_tag_heap_allocator_test passed");
      end else begin
         $display("boundary_tag_heap_allocator_test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
